@@ hdl/tag_radius_search_defines.svh @@
// ----------------------------------------------------------------------------
// tag_radius_search_defines
// Assertion macros shared by the radius search block.
// ----------------------------------------------------------------------------
`ifndef TAG_RADIUS_SEARCH_DEFINES_SVH
`define TAG_RADIUS_SEARCH_DEFINES_SVH

// same-cycle implication, clocked on clk, off while in reset
`define TRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/trs_pkg.sv @@
// ----------------------------------------------------------------------------
// trs_pkg
// Types and constants of the tag radius search block.
// ----------------------------------------------------------------------------
package trs_pkg;

    localparam int TAGS  = 16;
    localparam int CNT_W = $clog2(TAGS + 1);
    localparam int IDX_W = (TAGS > 1) ? $clog2(TAGS) : 1;

    localparam int        ADDR_W       = 3;
    localparam logic [15:0] RADIUS_RESET = 16'd100;

    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_QUERY  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] z;
        logic [15:0] y;
        logic [15:0] x;
    } tag_t;

    // control of one slot token walking into the distance pipeline
    typedef struct packed {
        logic vld;
        logic en;   // slot holds a valid tag
        logic fin;  // end marker after the last slot
    } scan_tok_t;

    typedef struct packed {
        logic        vld;
        logic        hit;
        logic        fin;
        logic [31:0] id;
    } match_t;

endpackage

@@ hdl/trs_cell.sv @@
// ----------------------------------------------------------------------------
// trs_cell
// One table slot. Loads a new tag or takes its neighbor's tag on a shift.
// ----------------------------------------------------------------------------
module trs_cell
    import trs_pkg::*;
(
    input  logic clk,
    input  logic shift,
    input  logic load,
    input  tag_t load_tag,
    input  tag_t shift_in,
    output tag_t tag
);

    tag_t tag_reg;
    tag_t tag_next;

    always_comb
    begin
        tag_next = tag_reg;
        if (shift)
        begin
            tag_next = shift_in;
        end
        else if (load)
        begin
            tag_next = load_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    assign tag = tag_reg;

endmodule

@@ hdl/trs_dist.sv @@
// ----------------------------------------------------------------------------
// trs_dist
// Three-stage squared distance test: differences, squares, sum and compare.
// ----------------------------------------------------------------------------
module trs_dist
    import trs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  scan_tok_t   tok,
    input  tag_t        tag,
    input  logic [15:0] qx,
    input  logic [15:0] qy,
    input  logic [15:0] qz,
    input  logic [31:0] r2,
    output match_t      res
);

    scan_tok_t          tok1_reg, tok2_reg;
    logic [31:0]        id1_reg, id2_reg;
    logic signed [16:0] dx_reg, dy_reg, dz_reg;
    logic [31:0]        sx_reg, sy_reg, sz_reg;
    logic               res_vld_reg, res_hit_reg, res_fin_reg;
    logic [31:0]        res_id_reg;

    logic signed [16:0] dx_next, dy_next, dz_next;
    logic signed [33:0] px, py, pz;
    logic [33:0]        sum;

    assign dx_next = $signed({qx[15], qx}) - $signed({tag.x[15], tag.x});
    assign dy_next = $signed({qy[15], qy}) - $signed({tag.y[15], tag.y});
    assign dz_next = $signed({qz[15], qz}) - $signed({tag.z[15], tag.z});

    // |d| <= 65535, so each square fits in 32 bits
    assign px = 34'(dx_reg) * 34'(dx_reg);
    assign py = 34'(dy_reg) * 34'(dy_reg);
    assign pz = 34'(dz_reg) * 34'(dz_reg);

    assign sum = {2'b00, sx_reg} + {2'b00, sy_reg} + {2'b00, sz_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok1_reg    <= '0;
            tok2_reg    <= '0;
            res_vld_reg <= 1'b0;
            res_hit_reg <= 1'b0;
            res_fin_reg <= 1'b0;
        end
        else if (advance)
        begin
            tok1_reg    <= tok;
            tok2_reg    <= tok1_reg;
            res_vld_reg <= tok2_reg.vld;
            res_fin_reg <= tok2_reg.fin;
            res_hit_reg <= tok2_reg.vld && tok2_reg.en && !tok2_reg.fin
                           && (sum <= {2'b00, r2});
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            dz_reg     <= dz_next;
            id1_reg    <= tag.id;
            sx_reg     <= px[31:0];
            sy_reg     <= py[31:0];
            sz_reg     <= pz[31:0];
            id2_reg    <= id1_reg;
            res_id_reg <= id2_reg;
        end
    end

    assign res = '{vld: res_vld_reg, hit: res_hit_reg, fin: res_fin_reg, id: res_id_reg};

endmodule

@@ hdl/tag_radius_search.sv @@
// ----------------------------------------------------------------------------
// tag_radius_search
// Fixed-radius 3-D neighbor search over a rotating ring of tag cells.
// ----------------------------------------------------------------------------
// Append, clear and reserved requests: one result, valid the cycle after accept.
// Query: the ring rotates through all TAGS slots plus one end slot, then 3 pipeline
//   stages; the result side can stall the scan. One request at a time.
// Rate set by the ring: one tag compared per cycle unless the result side stalls.
// Reset: tag count 0, radius 100, pipeline empty; tag cells are not cleared.
`include "tag_radius_search_defines.svh"

module tag_radius_search
    import trs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // slave request channel
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [79:0]       s_tdata,   // pos_x, pos_y, pos_z, new_tag_id
    input  logic [1:0]        s_tuser,   // action
    // master result channel
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // found_id
    output logic [1:0]        m_tuser,   // hit, status
    output logic              m_tlast,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    state_t state_reg, state_next;

    logic [15:0]      radius_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] slot_reg, slot_next;
    logic [15:0]      qx_reg, qy_reg, qz_reg;
    logic [31:0]      r2_reg;
    logic             pend_vld_reg, pend_vld_next;
    logic [31:0]      pend_id_reg, pend_id_next;

    logic             m_valid_reg, m_valid_next;
    logic [31:0]      m_id_reg, m_id_next;
    logic             m_hit_reg, m_hit_next;
    logic             m_last_reg, m_last_next;
    logic             m_status_reg, m_status_next;

    logic        advance;
    logic        accept;
    logic        is_query;
    logic        append_wr;
    logic        issue;
    logic        shift;
    scan_tok_t   tok;
    match_t      res;
    tag_t        new_tag;
    tag_t        cell_tag [TAGS];

    assign advance  = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_query = (s_tuser == ACT_QUERY);
    assign append_wr = accept && (s_tuser == ACT_APPEND) && (count_reg < CNT_W'(TAGS));

    assign new_tag.x  = s_tdata[15:0];
    assign new_tag.y  = s_tdata[31:16];
    assign new_tag.z  = s_tdata[47:32];
    assign new_tag.id = s_tdata[79:48];

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, radius_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
        begin
            radius_reg <= pwdata[15:0];
        end
    end

    // state machine: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_query)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (advance && (slot_reg == CNT_W'(TAGS)))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (advance && res.vld && res.fin)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state machine: outputs
    always_comb
    begin
        s_tready = 1'b0;
        issue    = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = advance;
            ST_SCAN:  issue    = advance;
            ST_DRAIN: issue    = 1'b0;
            default:  issue    = 1'b0;
        endcase
    end

    // slot counter walks 0..TAGS; the last step sends the end marker
    assign shift   = issue && (slot_reg < CNT_W'(TAGS));
    assign tok.vld = issue;
    assign tok.en  = slot_reg < count_reg;
    assign tok.fin = (slot_reg == CNT_W'(TAGS));

    always_comb
    begin
        slot_next = slot_reg;
        if (issue)
        begin
            slot_next = (slot_reg == CNT_W'(TAGS)) ? '0 : slot_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (append_wr)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (accept && (s_tuser == ACT_CLEAR))
        begin
            count_next = '0;
        end
    end

    // ring of cells, cell 0 feeds the distance pipeline
    for (genvar i = 0; i < TAGS; i++)
    begin : g_cell
        trs_cell u_cell (
            .clk      (clk),
            .shift    (shift),
            .load     (append_wr && (count_reg[IDX_W-1:0] == IDX_W'(i))),
            .load_tag (new_tag),
            .shift_in (cell_tag[(i + 1) % TAGS]),
            .tag      (cell_tag[i])
        );
    end

    trs_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .tok     (tok),
        .tag     (cell_tag[0]),
        .qx      (qx_reg),
        .qy      (qy_reg),
        .qz      (qz_reg),
        .r2      (r2_reg),
        .res     (res)
    );

    // result selection: one match is held back until the next is known,
    // so the last one can carry tlast
    always_comb
    begin
        m_valid_next  = m_valid_reg;
        m_id_next     = m_id_reg;
        m_hit_next    = m_hit_reg;
        m_last_next   = m_last_reg;
        m_status_next = m_status_reg;
        pend_vld_next = pend_vld_reg;
        pend_id_next  = pend_id_reg;
        if (advance)
        begin
            m_valid_next  = 1'b0;
            m_id_next     = 32'd0;
            m_hit_next    = 1'b0;
            m_last_next   = 1'b1;
            m_status_next = STATUS_OK;
            priority if (accept && !is_query)
            begin
                m_valid_next = 1'b1;
                if ((s_tuser == ACT_APPEND) && !append_wr)
                begin
                    m_status_next = STATUS_FULL;
                end
            end
            else if (res.vld && res.fin)
            begin
                m_valid_next  = 1'b1;
                m_id_next     = pend_vld_reg ? pend_id_reg : 32'd0;
                m_hit_next    = pend_vld_reg;
                pend_vld_next = 1'b0;
            end
            else if (res.vld && res.hit)
            begin
                m_valid_next  = pend_vld_reg;
                m_id_next     = pend_id_reg;
                m_hit_next    = 1'b1;
                m_last_next   = 1'b0;
                pend_vld_next = 1'b1;
                pend_id_next  = res.id;
            end
            else
            begin
                pend_vld_next = pend_vld_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            slot_reg     <= '0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            slot_reg     <= slot_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg  <= pend_id_next;
        m_id_reg     <= m_id_next;
        m_hit_reg    <= m_hit_next;
        m_last_reg   <= m_last_next;
        m_status_reg <= m_status_next;
        if (accept && is_query)
        begin
            qx_reg <= new_tag.x;
            qy_reg <= new_tag.y;
            qz_reg <= new_tag.z;
            r2_reg <= {16'd0, radius_reg} * {16'd0, radius_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_id_reg;
    assign m_tuser  = {m_status_reg, m_hit_reg};
    assign m_tlast  = m_last_reg;

    `TRS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(TAGS), "tag count above table size")
    `TRS_ASSERT_NOW(a_idle_empty, state_reg == ST_IDLE, !res.vld && !pend_vld_reg, "pipeline busy while idle")
    `TRS_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == 32'd0, "miss result with nonzero id")
    `TRS_ASSERT_NEXT(a_query_scan, accept && is_query, state_reg == ST_SCAN, "query did not start a scan")

endmodule

@@ tb/tag_radius_search_tb.sv @@
// ----------------------------------------------------------------------------
// tag_radius_search_tb
// Self-checking bench for the radius search block. A directed table covers
// the empty table, extreme coordinates, a tag on the radius boundary, a full
// table, clear and the reserved action. Random phases then run at several
// radius settings with sender gaps, receiver stalls and one long receiver
// hold-off. Every result is checked against a behavioral tag table.
// ----------------------------------------------------------------------------
module tag_radius_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import trs_pkg::*;

    localparam logic [1:0]        ACT_RESERVED = 2'd3;
    localparam logic [ADDR_W-1:0] RADIUS_ADDR  = '0;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = TAGS + 12;

    typedef struct packed {
        logic [31:0] id;
        logic        hit;
        logic        last;
        logic        status;
    } result_t;

    typedef struct {
        logic [1:0]  act;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [31:0] id;
        bit          typed;  // res holds the expected result
        result_t     res;
    } request_t;

    localparam result_t DONE_RESULT = '{id: 32'd0, hit: 1'b0, last: 1'b1, status: STATUS_OK};
    localparam result_t FULL_RESULT = '{id: 32'd0, hit: 1'b0, last: 1'b1,
                                        status: STATUS_FULL};

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [79:0]       s_tdata;   // pos_x, pos_y, pos_z, new_tag_id
    logic [1:0]        s_tuser;   // action
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;   // found_id
    logic [1:0]        m_tuser;   // hit, status
    logic              m_tlast;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // behavioral tag table
    logic [15:0] tag_x [TAGS];
    logic [15:0] tag_y [TAGS];
    logic [15:0] tag_z [TAGS];
    logic [31:0] tag_id [TAGS];
    int          tag_count = 0;
    logic [15:0] radius_mm = RADIUS_RESET;

    result_t  pending_results [$];
    request_t directed_rows [$];
    request_t cur_req;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int hold_left      = 0;
    int center_x, center_y, center_z;

    int errors          = 0;
    int requests_taken  = 0;
    int results_checked = 0;
    int hits_seen       = 0;
    int full_seen       = 0;
    int idle_cycles     = 0;

    tag_radius_search uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        errors++;
        if (errors <= 30)
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    endtask

    // Appends one result to the tail of the expected queue.
    function automatic void expect_result(input result_t res);
        pending_results = {pending_results, res};
    endfunction

    // Expected results of one accepted request; updates the tag table.
    function automatic void predict_request(input request_t r);
        result_t res;
        longint  dx, dy, dz, r2;
        int      i;
        int      hits;
        hits = 0;
        res  = DONE_RESULT;
        case (r.act)
            ACT_APPEND:
            begin
                if (tag_count < TAGS)
                begin
                    tag_x[tag_count]  = r.x;
                    tag_y[tag_count]  = r.y;
                    tag_z[tag_count]  = r.z;
                    tag_id[tag_count] = r.id;
                    tag_count++;
                end
                else
                    res.status = STATUS_FULL;
            end
            ACT_QUERY:
            begin
                r2 = longint'(radius_mm) * longint'(radius_mm);
                for (i = 0; i < tag_count; i++)
                begin
                    dx = longint'($signed(r.x)) - longint'($signed(tag_x[i]));
                    dy = longint'($signed(r.y)) - longint'($signed(tag_y[i]));
                    dz = longint'($signed(r.z)) - longint'($signed(tag_z[i]));
                    if (dx * dx + dy * dy + dz * dz <= r2)
                    begin
                        hits++;
                        if (!r.typed)
                            expect_result('{id: tag_id[i], hit: 1'b1,
                                            last: 1'b0, status: STATUS_OK});
                    end
                end
                if (hits > 0 && !r.typed)
                begin
                    res = pending_results.pop_back();
                    res.last = 1'b1;
                    expect_result(res);
                end
            end
            ACT_CLEAR:
                tag_count = 0;
            default:
                ;
        endcase
        if (r.typed)
            expect_result(r.res);
        else if (hits == 0)
            expect_result(res);
    endfunction

    function automatic logic [15:0] near(input int c, input int span);
        return 16'(c + int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Mostly appends clustered around a center and queries close to stored
    // tags, so that queries return several hits; the rest is full-range noise.
    function automatic request_t random_request();
        request_t r;
        int       pick, k, idx, span;
        pick    = $urandom_range(99);
        k       = $urandom_range(9);
        span    = (radius_mm == 16'd0) ? 2 : int'(radius_mm);
        r.typed = 1'b0;
        r.res   = '0;
        r.id    = $urandom;
        r.x     = 16'($urandom);
        r.y     = 16'($urandom);
        r.z     = 16'($urandom);
        if (pick < 47)
        begin
            r.act = ACT_APPEND;
            if (k < 8)
            begin
                r.x = near(center_x, span);
                r.y = near(center_y, span);
                r.z = near(center_z, span);
            end
        end
        else if (pick < 92)
        begin
            r.act = ACT_QUERY;
            if (k < 5 && tag_count > 0)
            begin
                idx = $urandom_range(tag_count - 1);
                r.x = tag_x[idx];
                r.y = tag_y[idx];
                r.z = tag_z[idx];
                if (k >= 3)
                begin
                    r.x = near($signed(tag_x[idx]), span / 2);
                    r.y = near($signed(tag_y[idx]), span / 2);
                    r.z = near($signed(tag_z[idx]), span / 2);
                end
            end
            else if (k < 8)
            begin
                r.x = near(center_x, span);
                r.y = near(center_y, span);
                r.z = near(center_z, span);
            end
            else if (k == 9)
            begin
                r.x = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
                r.y = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
                r.z = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            end
        end
        else if (pick < 96)
            r.act = ACT_CLEAR;
        else
            r.act = ACT_RESERVED;
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] act, input logic [15:0] x,
                                    input logic [15:0] y, input logic [15:0] z,
                                    input logic [31:0] id, input bit typed,
                                    input result_t res);
        request_t r;
        r.act   = act;
        r.x     = x;
        r.y     = y;
        r.z     = z;
        r.id    = id;
        r.typed = typed;
        r.res   = res;
        directed_rows = {directed_rows, r};
    endfunction

    // Radius stays at its reset value of 100 mm throughout.
    function automatic void build_directed();
        int i;
        add_row(ACT_QUERY, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b1, DONE_RESULT);
        add_row(ACT_RESERVED, 16'h7FFF, 16'h8000, 16'h0000, 32'hFFFF_FFFF, 1'b1,
                DONE_RESULT);
        add_row(ACT_APPEND, 16'h8000, 16'h8000, 16'h8000, 32'hFFFF_FFFF, 1'b1, DONE_RESULT);
        add_row(ACT_APPEND, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h0000_0000, 1'b1, DONE_RESULT);
        add_row(ACT_APPEND, 16'h0000, 16'h0000, 16'h0000, 32'h1234_5678, 1'b1, DONE_RESULT);
        add_row(ACT_APPEND, 16'd50, 16'h0000, 16'h0000, 32'hA5A5_A5A5, 1'b1, DONE_RESULT);
        // exactly on the radius
        add_row(ACT_APPEND, 16'h0000, 16'hFF9C, 16'h0000, 32'h5A5A_5A5A, 1'b1, DONE_RESULT);
        // just inside and just outside along the diagonal
        add_row(ACT_APPEND, 16'd57, 16'd57, 16'd57, 32'h0000_0057, 1'b1, DONE_RESULT);
        add_row(ACT_APPEND, 16'd58, 16'd58, 16'd58, 32'h0000_0058, 1'b1, DONE_RESULT);
        add_row(ACT_QUERY, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b0, '0);
        add_row(ACT_QUERY, 16'h8000, 16'h8000, 16'h8000, 32'h0, 1'b0, '0);
        add_row(ACT_QUERY, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h0, 1'b0, '0);
        for (i = 0; i < 9; i++)
            add_row(ACT_APPEND, 16'(i * 7 - 30), 16'(20 - i * 5), 16'(i * 11 - 40),
                    32'h100 + i, 1'b1, DONE_RESULT);
        add_row(ACT_APPEND, 16'h0001, 16'h0001, 16'h0001, 32'hDEAD_0001, 1'b1, FULL_RESULT);
        add_row(ACT_QUERY, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b0, '0);
        add_row(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b1, DONE_RESULT);
        add_row(ACT_QUERY, 16'h0000, 16'h0000, 16'h0000, 32'h0, 1'b1, DONE_RESULT);
    endfunction

    // Called and returns on a falling edge.
    task automatic send_request(input request_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        cur_req  = r;
        s_tdata  = {r.id, r.z, r.y, r.x};
        s_tuser  = r.act;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write then read back the radius register.
    task automatic write_radius(input logic [15:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = RADIUS_ADDR;
        pwdata  = {16'd0, value};
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        radius_mm = value;
        pwrite    = 1'b0;
        penable   = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata[15:0] !== value)
            report("radius readback", {16'd0, value}, prdata);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] radius, input int send_pct,
                             input int recv_pct, input int n, input bit pressure);
        request_t r;
        wait_idle();
        write_radius(radius);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        center_x = $signed(16'($urandom));
        center_y = $signed(16'($urandom));
        center_z = $signed(16'($urandom));
        if (pressure)
            hold_req = 1'b1;
        repeat (n)
        begin
            r = random_request();
            send_request(r);
        end
        s_tvalid = 1'b0;
    endtask

    // receiver: random stalls, or a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            m_tready = 1'b0;
            hold_left--;
        end
        else
            m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            requests_taken++;
            predict_request(cur_req);
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_checked++;
            if (m_tuser[0])
                hits_seen++;
            if (m_tuser[1] == STATUS_FULL)
                full_seen++;
            if (pending_results.size() == 0)
                report("unexpected result, found_id", 32'h0, m_tdata);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata !== want.id)
                    report("found_id", want.id, m_tdata);
                if (m_tuser[0] !== want.hit)
                    report("hit", 32'(want.hit), 32'(m_tuser[0]));
                if (m_tlast !== want.last)
                    report("last", 32'(want.last), 32'(m_tlast));
                if (m_tuser[1] !== want.status)
                    report("status", 32'(want.status), 32'(m_tuser[1]));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_APPEND;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = RADIUS_ADDR;
        pwdata   = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        build_directed();
        @(negedge clk);
        foreach (directed_rows[i])
            send_request(directed_rows[i]);
        s_tvalid = 1'b0;

        run_phase(16'hFFFF, 0, 0, 17, 1'b0);
        run_phase(16'd0, 81, 0, 17, 1'b0);
        run_phase(16'($urandom_range(200, 5000)), 0, 81, 17, 1'b0);
        run_phase(16'd1000, 7, 7, 17, 1'b0);
        run_phase(16'd300, 0, 0, 17, 1'b1);
        wait_idle();

        $display("Covered %0d requests and %0d results (%0d hits, %0d full refusals)",
                 requests_taken, results_checked, hits_seen, full_seen);
        $display("over radius 100, 0, 65535 and mid values, with gaps, stalls and a hold-off.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
